// ===== design/srs_pkg.sv =====
`default_nettype none

package srs_pkg;

  // window and sequence space
  localparam int Window    = 4;
  localparam int SeqBits   = 16;
  localparam int Slots     = 2 * Window;
  localparam int SlotBits  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam longint HalfSpace = longint'(1) << (SeqBits - 1);
  localparam longint EffWin    = (longint'(Window) < HalfSpace) ? longint'(Window) : HalfSpace;

  // stored message width: bytes 0-7, 8-15, 16-20
  localparam int Pay0Bits    = 64;
  localparam int Pay1Bits    = 64;
  localparam int Pay2Bits    = 40;
  localparam int PayloadBits = Pay0Bits + Pay1Bits + Pay2Bits;

  typedef logic [SeqBits-1:0]  seq_t;
  typedef logic [SlotBits-1:0] slot_t;

  localparam seq_t EffWinSeq = seq_t'(EffWin);

  // operation codes
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SLIDE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [Pay0Bits-1:0] payload_0;
    logic [Pay1Bits-1:0] payload_1;
    logic [Pay2Bits-1:0] payload_2;
    seq_t                ack_number;
    logic                ack_checksum_ok;
    seq_t                expired_seq;
  } in_t;

  typedef struct packed {
    logic                accepted;
    logic                transmit;
    seq_t                tx_seq;
    logic [Pay0Bits-1:0] tx_payload_0;
    logic [Pay1Bits-1:0] tx_payload_1;
    logic [Pay2Bits-1:0] tx_payload_2;
    logic                timer_start;
    logic                timer_stop;
    seq_t                timer_seq;
    seq_t                window_base;
    logic                window_full;
  } out_t;

  // results of the shared sequence arithmetic unit
  typedef struct packed {
    seq_t outst;
    seq_t ack_dist;
    logic dist_lt;
    logic outst_lt_win;
    logic fills;
    seq_t base_inc;
    seq_t next_inc;
  } seq_res_t;

  function automatic slot_t slot_of(input seq_t seq);
    slot_of = slot_t'(seq % Slots);
  endfunction

endpackage

`default_nettype wire

// ===== design/srs_ram.sv =====
`default_nettype none

module srs_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/srs_seq_unit.sv =====
`default_nettype none

module srs_seq_unit (
  input  wire logic            [srs_pkg::SeqBits-1:0] base_i,
  input  wire logic            [srs_pkg::SeqBits-1:0] next_i,
  input  wire logic            [srs_pkg::SeqBits-1:0] arg_i,
  output srs_pkg::seq_res_t                           res_o
);

  srs_pkg::seq_t outst;
  srs_pkg::seq_t ack_dist;
  srs_pkg::seq_t outst_inc;

  // distances relative to the window base, modulo the sequence space
  assign outst     = srs_pkg::seq_t'(next_i - base_i);
  assign ack_dist  = srs_pkg::seq_t'(arg_i - base_i);
  assign outst_inc = srs_pkg::seq_t'(outst + srs_pkg::seq_t'(1));

  assign res_o.outst        = outst;
  assign res_o.ack_dist     = ack_dist;
  assign res_o.dist_lt      = ack_dist < outst;
  assign res_o.outst_lt_win = outst < srs_pkg::EffWinSeq;
  assign res_o.fills        = outst_inc >= srs_pkg::EffWinSeq;
  assign res_o.base_inc     = srs_pkg::seq_t'(base_i + srs_pkg::seq_t'(1));
  assign res_o.next_inc     = srs_pkg::seq_t'(next_i + srs_pkg::seq_t'(1));

endmodule

`default_nettype wire

// ===== design/selective_repeat_sender_core.sv =====
// Selective-repeat ARQ sender core.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one event per
// transfer: op send stores and transmits the message if not full, op ack
// marks or slides the window, op timeout retransmits the stored slot. Each
// event yields exactly one result transfer on out_valid_o / out_stall_i /
// out_data_o, carrying transmit, timer commands, window base and full flag.
// The path from the input transfer to the loaded output register runs
// through the event register and state EXEC for send, ignored ack, ack
// above base and unknown op; a timeout adds state READ (registered read of
// the message store); an ack of the base adds state SLIDE, which slides the
// window by one to Window slots, one slot per cycle through the shared
// sequence unit. The input reopens in the cycle after the load.
// One event is processed at a time; in_stall_o is high from the transfer
// until the result is loaded. The output register holds one result, so an
// event can be taken while the previous result waits; a stalled receiver
// then holds the core in its last step without side effects. Reset clears
// base, next sequence, full flag, acknowledge marks and output valid; the
// message store is not cleared and needs no clearing pass.
`default_nettype none

module selective_repeat_sender_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire srs_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output srs_pkg::out_t      out_data_o
);

  srs_pkg::state_e           state_q, state_d;
  srs_pkg::in_t              item_q;
  srs_pkg::seq_t             base_q, base_d;
  srs_pkg::seq_t             next_q, next_d;
  logic                      full_q, full_d;
  logic [srs_pkg::Slots-1:0] marks_q, marks_d;
  srs_pkg::out_t             out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  srs_pkg::out_t             res;
  logic                      finish;
  logic                      out_free;
  logic                      in_xfer;

  srs_pkg::seq_res_t         su;
  logic                      ram_we;
  logic                      ram_re;
  logic [srs_pkg::PayloadBits-1:0] ram_rdata;

  srs_pkg::slot_t            slot_next;
  srs_pkg::slot_t            slot_ack;
  srs_pkg::slot_t            slot_base;
  srs_pkg::slot_t            slot_exp;

  assign in_stall_o  = (state_q != srs_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign slot_next = srs_pkg::slot_of(next_q);
  assign slot_ack  = srs_pkg::slot_of(item_q.ack_number);
  assign slot_base = srs_pkg::slot_of(base_q);
  assign slot_exp  = srs_pkg::slot_of(item_q.expired_seq);

  // shared sequence arithmetic
  srs_seq_unit u_seq (
    .base_i (base_q),
    .next_i (next_q),
    .arg_i  (item_q.ack_number),
    .res_o  (su)
  );

  // message store, one slot per outstanding sequence number
  srs_ram #(
    .Width (srs_pkg::PayloadBits),
    .Depth (srs_pkg::Slots)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_next),
    .wdata_i ({item_q.payload_0, item_q.payload_1, item_q.payload_2}),
    .re_i    (ram_re),
    .raddr_i (slot_exp),
    .rdata_o (ram_rdata)
  );

  // event register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srs_pkg::ST_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      full_q      <= 1'b0;
      marks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      full_q      <= full_d;
      marks_q     <= marks_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sequencer: next state, window update and result
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    full_d      = full_q;
    marks_d     = marks_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    finish      = 1'b0;
    res         = '0;

    unique case (state_q)
      srs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = srs_pkg::ST_EXEC;
        end
      end

      srs_pkg::ST_EXEC: begin
        if (out_free) begin
          unique case (item_q.op)
            srs_pkg::OP_SEND: begin
              finish = 1'b1;
              if (!full_q) begin
                res.accepted = 1'b1;
                if (su.outst_lt_win) begin
                  ram_we             = 1'b1;
                  marks_d[slot_next] = 1'b0;
                  res.transmit       = 1'b1;
                  res.tx_seq         = next_q;
                  res.tx_payload_0   = item_q.payload_0;
                  res.tx_payload_1   = item_q.payload_1;
                  res.tx_payload_2   = item_q.payload_2;
                  res.timer_start    = 1'b1;
                  res.timer_seq      = next_q;
                  next_d             = su.next_inc;
                  if (su.fills) begin
                    full_d = 1'b1;
                  end
                end
              end
            end
            srs_pkg::OP_ACK: begin
              finish = 1'b1;
              if (item_q.ack_checksum_ok && su.dist_lt) begin
                res.timer_stop = 1'b1;
                res.timer_seq  = item_q.ack_number;
                if (su.ack_dist == '0) begin
                  // base acknowledged: walk the window forward
                  marks_d[slot_ack] = 1'b1;
                  full_d            = 1'b0;
                  finish            = 1'b0;
                  state_d           = srs_pkg::ST_SLIDE;
                end else if (!marks_q[slot_ack]) begin
                  marks_d[slot_ack] = 1'b1;
                end else begin
                  res.timer_stop = 1'b0;
                  res.timer_seq  = '0;
                end
              end
            end
            srs_pkg::OP_TIMEOUT: begin
              ram_re  = 1'b1;
              state_d = srs_pkg::ST_READ;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      srs_pkg::ST_SLIDE: begin
        if (base_q != next_q && marks_q[slot_base]) begin
          marks_d[slot_base] = 1'b0;
          base_d             = su.base_inc;
        end else if (out_free) begin
          res.timer_stop = 1'b1;
          res.timer_seq  = item_q.ack_number;
          finish         = 1'b1;
        end
      end

      srs_pkg::ST_READ: begin
        if (out_free) begin
          res.transmit     = 1'b1;
          res.tx_seq       = item_q.expired_seq;
          res.tx_payload_0 = ram_rdata[srs_pkg::PayloadBits-1 -: srs_pkg::Pay0Bits];
          res.tx_payload_1 = ram_rdata[srs_pkg::Pay2Bits +: srs_pkg::Pay1Bits];
          res.tx_payload_2 = ram_rdata[srs_pkg::Pay2Bits-1:0];
          res.timer_start  = 1'b1;
          res.timer_seq    = item_q.expired_seq;
          finish           = 1'b1;
        end
      end

      default: begin
        state_d = srs_pkg::ST_IDLE;
      end
    endcase

    // load the output register with the finished result
    if (finish) begin
      res.window_base = base_d;
      res.window_full = full_d;
      out_d           = res;
      out_valid_d     = 1'b1;
      state_d         = srs_pkg::ST_IDLE;
    end
  end

  // the full flag means exactly a whole window is outstanding
  a_full_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (srs_pkg::seq_t'(next_q - base_q) == srs_pkg::EffWinSeq))
    else $error("full flag set without a full window");

  // never more packets outstanding than the window holds
  a_outst_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    srs_pkg::seq_t'(next_q - base_q) <= srs_pkg::EffWinSeq)
    else $error("outstanding count beyond window");

  // every transmit restarts a timer and no result both starts and stops one
  a_tx_timer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.transmit == out_data_o.timer_start)
                    && !(out_data_o.timer_start && out_data_o.timer_stop))
    else $error("inconsistent timer command in result");

  // a taken event keeps the input side closed in the next cycle
  a_busy_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after a transfer");

endmodule

`default_nettype wire
